### rtl/sha_pkg.sv
package sha_pkg;

	localparam int RoundCount = 64;

	function automatic logic [31:0] round_const(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		logic [31:0] h;
		case (idx)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LengthPos = 6'd56;

	// Command codes
	localparam logic CmdAbsorb = 1'b0;
	localparam logic CmdFinish = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PAD   = 7'b0000010,
		ST_LOAD  = 7'b0000100,
		ST_ROUND = 7'b0001000,
		ST_FOLD  = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_LEN   = 7'b1000000
	} state_t;

endpackage

### rtl/sha_ram.sv
module sha_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### rtl/sha256_byte_stream_hasher.sv
// SHA-256 hasher over a byte stream. Each request carries cmd (absorb=0, finish=1) and a
// byte. An absorb only writes its byte to the RAM, except that the 64th byte of a block
// starts the compression: the sixteen schedule words are loaded from the
// byte RAM, then come 64 rounds at one per cycle and a hash fold, and the
// input is held off until the fold is done. Message bytes sit in a 64-byte
// RAM. The first 16 schedule words come from a 16-entry RAM whose read
// address leads the round by one entry; later words are built from a 16-word
// shift window. A finish pads the block (one cycle per byte written: the 0x80
// byte, zeros up to byte 55 and then the 8 length bytes), compresses once or
// twice, then sends eight digest words, word 0 first, with last on word 7,
// and resets the hash for the next message. A block that holds f bytes is
// padded and compressed, and when f is 56 or more a second block is padded
// and compressed as well; the digest words then go out one per cycle while
// the receiver is ready. The input is not taken again until the digest is out.
module sha256_byte_stream_hasher
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
	output logic        m_tlast    // last_word
);
	state_t      state_q;
	logic [31:0] h_q [8];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic        finish_q;      // compressing as part of finish
	logic        len_pending_q; // 0x80 already written; on a full block, length block follows
	logic [6:0]  cnt_q;         // load/round counter
	logic [2:0]  widx_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [31:0] w_s1;          // word being assembled during load

	// message byte RAM
	logic       mb_we;
	logic [5:0] mb_waddr, mb_raddr;
	logic [7:0] mb_wdata, mb_rdata;
	sha_ram #(.Width(8), .Depth(64)) u_msg (
		.clk, .we(mb_we), .waddr(mb_waddr), .wdata(mb_wdata),
		.raddr(mb_raddr), .rdata(mb_rdata));

	// schedule word RAM, entry t for words 0..15
	logic        w_we;
	logic [3:0]  w_waddr, w_raddr;
	logic [31:0] w_wdata, w_rdata;
	sha_ram #(.Width(32), .Depth(16)) u_sched (
		.clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata));

	// Schedule words for round t >= 16 need four window taps; hold a 16-deep
	// shift of the window instead of four RAM reads: keep taps in registers.
	logic [31:0] win_q [16];

	function automatic logic [31:0] rr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	logic [5:0]  rnd;
	logic [31:0] wt, t1, t2, s0, s1;
	assign rnd = cnt_q[5:0];
	always_comb begin
		s0 = rr(win_q[1], 7) ^ rr(win_q[1], 18) ^ (win_q[1] >> 3);
		s1 = rr(win_q[14], 17) ^ rr(win_q[14], 19) ^ (win_q[14] >> 10);
		wt = (rnd < 6'd16) ? w_rdata : (win_q[0] + s0 + win_q[9] + s1);
		t1 = hh_q + (rr(e_q, 6) ^ rr(e_q, 11) ^ rr(e_q, 25))
			+ ((e_q & f_q) ^ (~e_q & g_q)) + round_const(rnd) + wt;
		t2 = (rr(a_q, 2) ^ rr(a_q, 13) ^ rr(a_q, 22))
			+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	logic take;
	assign s_tready = (state_q == ST_IDLE);
	assign take = s_tvalid && s_tready;

	// Length byte written at position 56+k holds bits_q byte 7-k.
	logic [2:0] lsel;
	assign lsel = 3'd7 - fill_q[2:0];

	always_comb begin
		mb_we = 1'b0;
		mb_waddr = fill_q;
		mb_wdata = s_tdata;
		if (take && s_tuser == CmdAbsorb) mb_we = 1'b1;
		if (state_q == ST_PAD) begin
			mb_we = 1'b1;
			mb_wdata = (!len_pending_q) ? PadByte : 8'h00;
		end
		if (state_q == ST_LEN) begin
			mb_we = 1'b1;
			mb_wdata = bits_q[{lsel, 3'b000} +: 8];
		end
	end
	// load phase: cnt 0..64 reads bytes, word done every 4th
	assign mb_raddr = cnt_q[5:0];
	assign w_we = (state_q == ST_LOAD) && (cnt_q[1:0] == 2'd0) && (cnt_q != 7'd0);
	assign w_waddr = cnt_q[5:2] - 4'd1;
	assign w_wdata = {w_s1[23:0], mb_rdata};
	assign w_raddr = (state_q == ST_LOAD) ? 4'd0 : rnd[3:0] + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			finish_q <= 1'b0;
			len_pending_q <= 1'b0;
			cnt_q <= '0;
			widx_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else begin
			case (state_q)
				ST_IDLE: if (take) begin
					if (s_tuser == CmdAbsorb) begin
						bits_q <= bits_q + 64'd8;
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin
							state_q <= ST_LOAD;
							cnt_q <= '0;
						end
					end else begin
						finish_q <= 1'b1;
						len_pending_q <= 1'b0;
						state_q <= ST_PAD;
					end
				end
				// write 0x80 then zeros up to the length slot or block end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						state_q <= ST_LOAD;
						cnt_q <= '0;
					end else if (fill_q + 6'd1 == LengthPos) begin
						state_q <= ST_LEN;
					end
					// after the first pad byte, subsequent bytes are zero
					len_pending_q <= 1'b1;
				end
				ST_LEN: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						len_pending_q <= 1'b0;
						state_q <= ST_LOAD;
						cnt_q <= '0;
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd64) begin
						cnt_q <= '0;
						state_q <= ST_ROUND;
						a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
						e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
					end
				end
				ST_ROUND: begin
					hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
					d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
					h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
					fill_q <= '0;
					if (!finish_q) state_q <= ST_IDLE;
					else if (len_pending_q) state_q <= ST_PAD;
					else begin
						state_q <= ST_EMIT;
						widx_q <= '0;
					end
				end
				ST_EMIT: if (m_tready) begin
					widx_q <= widx_q + 3'd1;
					if (widx_q == 3'd7) begin
						state_q <= ST_IDLE;
						finish_q <= 1'b0;
						len_pending_q <= 1'b0;
						bits_q <= '0;
						fill_q <= '0;
						for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// byte assembly and schedule window shift
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) w_s1 <= {w_s1[23:0], mb_rdata};
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= wt;
		end
	end

	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata = {5'd0, widx_q, h_q[widx_q]};
	assign m_tlast = (widx_q == 3'd7);
endmodule

### rtl/sha_checker.sv
module sha_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tlast
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input open during digest");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("digest dropped");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid) else $error("extra word");
endmodule

bind sha256_byte_stream_hasher sha_checker u_chk (.*);

### tb/sha256_byte_stream_hasher_test.sv
`timescale 1ns / 1ps

// Checks the SHA-256 byte-stream hasher against a behavioral hash model.
// Messages of directed and random length go in byte by byte, each closed by a finish
// request; the eight digest words that come back are compared field by field.
module sha256_byte_stream_hasher_test
	import sha_pkg::*;
();

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} request_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	sha256_byte_stream_hasher dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	request_t     pending_requests[$];
	digest_beat_t expected_digest[$];
	int           error_count = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           hold_off_cycles = 600; // long receiver hold-off right after reset
	longint       cycle_count = 0;

	// Hasher model state
	logic [31:0] hash_state[8];
	logic [7:0]  block_bytes[64];
	logic [5:0]  fill_count;
	logic [63:0] bit_length;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = w[t-16] + w[t-7]
				+ (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
				+ (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
		v = hash_state;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(t[5:0]) + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int t = 0; t < 8; t++) hash_state[t] += v[t];
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++) hash_state[i] = init_hash(i[2:0]);
		fill_count = '0;
		bit_length = '0;
	endtask

	// Fold one accepted request into the model; a finish queues the digest.
	task automatic hash_request(input request_t req);
		int pos;
		digest_beat_t beat;
		if (req.cmd == CmdAbsorb) begin
			block_bytes[fill_count] = req.data_byte;
			bit_length += 64'd8;
			fill_count++;
			if (fill_count == 0) compress();
		end else begin
			pos = fill_count;
			block_bytes[pos++] = PadByte;
			// long tail: no room for the length, so spill into a second block
			if (pos > LengthPos) begin
				while (pos < 64) block_bytes[pos++] = 8'h00;
				compress();
				pos = 0;
			end
			while (pos < LengthPos) block_bytes[pos++] = 8'h00;
			for (int k = 0; k < 8; k++) block_bytes[63-k] = bit_length[8*k +: 8];
			compress();
			for (int k = 0; k < 8; k++) begin
				beat.digest_word = hash_state[k];
				beat.word_index  = k[2:0];
				beat.last_word   = (k == 7);
				expected_digest.push_back(beat);
			end
			restart_hash();
		end
	endtask

	task automatic report(input string what);
		$display("ERROR at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	task automatic queue_message(input int len, input int pattern);
		request_t req;
		for (int i = 0; i < len; i++) begin
			req.cmd = CmdAbsorb;
			case (pattern)
				0: req.data_byte = 8'h00;
				1: req.data_byte = 8'hff;
				default: req.data_byte = 8'($urandom_range(0, 255));
			endcase
			pending_requests.push_back(req);
		end
		req.cmd = CmdFinish;
		req.data_byte = 8'($urandom_range(0, 255)); // ignored on finish, drive it anyway
		pending_requests.push_back(req);
	endtask

	// Driver: offer the head of the queue, advance on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				hash_request({s_tuser, s_tdata});
				void'(pending_requests.pop_front());
			end
			if ((!s_tvalid || s_tready) ) begin
				if (pending_requests.size() > (s_tvalid && s_tready ? 0 : 0) &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					{s_tuser, s_tdata} <= pending_requests[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Hold-off counter: count down the receiver stall after reset
	always @(posedge clk) begin
		if (arst_n && hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
	end

	// Monitor: check each accepted digest word, then pick the next ready level
	always @(posedge clk or negedge arst_n) begin
		digest_beat_t exp_beat;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (m_tvalid && m_tready) begin
				if (expected_digest.size() == 0) begin
					report($sformatf("unexpected digest word %h", m_tdata));
				end else begin
					exp_beat = expected_digest.pop_front();
					if (m_tdata[31:0] !== exp_beat.digest_word)
						report($sformatf("digest_word %h, want %h",
							m_tdata[31:0], exp_beat.digest_word));
					if (m_tdata[34:32] !== exp_beat.word_index)
						report($sformatf("word_index %0d, want %0d",
							m_tdata[34:32], exp_beat.word_index));
					if (m_tlast !== exp_beat.last_word)
						report($sformatf("last_word %b, want %b", m_tlast, exp_beat.last_word));
				end
			end
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic drain();
		while (pending_requests.size() != 0 || s_tvalid || expected_digest.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		restart_hash();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty message, byte extremes, block boundaries and long tails.
		// The receiver holds off at first while the sender keeps offering.
		queue_message(0, 2);
		queue_message(1, 0);
		queue_message(1, 1);
		queue_message(3, 2);
		queue_message(55, 2);
		queue_message(56, 1);
		queue_message(63, 2);
		queue_message(64, 0);
		queue_message(0, 2);

		send_idle_pct = 6; recv_idle_pct = 66;
		for (int n = 0; n < 4; n++) queue_message($urandom_range(0, 20), 2);
		drain();
		send_idle_pct = 66; recv_idle_pct = 6;
		for (int n = 0; n < 4; n++) queue_message($urandom_range(0, 20), 2);
		drain();
		send_idle_pct = 0; recv_idle_pct = 0;
		for (int n = 0; n < 4; n++) queue_message($urandom_range(0, 20), 2);
		drain();
		repeat (200) @(posedge clk);

		if (error_count == 0) begin
			$display("sha256_byte_stream_hasher_test passed");
		end else begin
			$display("sha256_byte_stream_hasher_test failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		wait (cycle_count >= 400000);
		$display("sha256_byte_stream_hasher_test failed");
		$finish;
	end

endmodule

### filelist.f
rtl/sha_pkg.sv
rtl/sha_ram.sv
rtl/sha256_byte_stream_hasher.sv
rtl/sha_checker.sv
tb/sha256_byte_stream_hasher_test.sv
